@@ hw/rtl/lpfp_pkg.sv @@
// ============================================================================
// lpfp_pkg: shared types and codes of the length-prefixed field parser
// Transaction structs for both channels, result kinds and reject reasons.
// ============================================================================
package lpfp_pkg;

    // Input transaction: one line byte or an end-of-line marker
    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } in_item_t;

    // Output transaction: payload byte, empty field, or line verdict
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [7:0] field_index;
        logic       last_of_field;
        logic [2:0] reject_reason;
    } out_item_t;

    // func codes
    localparam logic FUNC_DATA = 1'b0;
    localparam logic FUNC_EOL  = 1'b1;

    // kind codes
    localparam logic [1:0] KIND_PAYLOAD = 2'd0;
    localparam logic [1:0] KIND_EMPTY   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT  = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    // reject reasons
    localparam logic [2:0] REASON_NONE      = 3'd0;
    localparam logic [2:0] REASON_FEW       = 3'd1;
    localparam logic [2:0] REASON_BAD_TEXT  = 3'd2;
    localparam logic [2:0] REASON_TOO_LARGE = 3'd3;
    localparam logic [2:0] REASON_TRUNCATED = 3'd4;

    localparam logic [7:0] COLON_CHAR = 8'h3A;

    localparam logic [15:0] MAX_LENGTH_RESET = 16'hFFFF;

endpackage

@@ hw/rtl/length_prefixed_field_parser.sv @@
// ============================================================================
// length_prefixed_field_parser: netstring-style line decoder
// Decodes decimal-length-prefixed fields byte by byte and emits payload bytes,
// empty-field marks and an accept or reject verdict at end of line.
// ============================================================================
// Path from input transaction to output transaction: input register, then
//   parse step into the result register.
// Throughput: one byte per cycle unless a result waits on a stalled output.
// Reset (rst_n low, asynchronous): line state clears, both channels empty,
//   max_length returns to 65535.
// ============================================================================
module length_prefixed_field_parser
    import lpfp_pkg::*;
#(
    parameter int LENGTH_BITS = 16,
    parameter int COUNT_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: max_length register
    input  logic        cfg_write,
    input  logic [15:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    logic [15:0] max_length_reg;
    logic        item_valid;
    in_item_t    item;
    logic        taken;

    // Hold the length limit; write it only while the parser is idle (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            max_length_reg <= cfg_data;
        end
    end

    // Input register: takes a new transaction whenever the held one moves on,
    // so the input stalls only while a held byte with a result waits on a
    // stalled output.
    lpfp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .taken      (taken),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parse step: advance the line state by one byte and load the result
    // register. Bytes that give no result are consumed even while the output
    // is stalled.
    lpfp_parse #(
        .LENGTH_BITS (LENGTH_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .max_length (max_length_reg),
        .item_valid (item_valid),
        .item       (item),
        .taken      (taken),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_item   (out_item)
    );

endmodule

@@ hw/rtl/lpfp_in_stage.sv @@
// ============================================================================
// lpfp_in_stage: input register of the parser
// Holds one accepted transaction until the parse stage takes it.
// ============================================================================
module lpfp_in_stage
    import lpfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    input  logic     taken,
    output logic     item_valid,
    output in_item_t item
);

    logic     valid_reg;
    in_item_t item_reg;

    // stall only while a held transaction cannot move on this cycle
    assign in_stall   = valid_reg && !taken;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            valid_reg <= 1'b1;
        end
        else if (taken)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg <= in_item;
        end
    end

endmodule

@@ hw/rtl/lpfp_parse.sv @@
// ============================================================================
// lpfp_parse: per-byte parse step and result register
// Updates the line state for one byte and loads at most one result.
// ============================================================================
module lpfp_parse
    import lpfp_pkg::*;
#(
    parameter int LENGTH_BITS = 16,
    parameter int COUNT_BITS  = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] max_length,
    input  logic        item_valid,
    input  in_item_t    item,
    output logic        taken,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item
);

    localparam int LW   = LENGTH_BITS;
    localparam int VW   = LENGTH_BITS + 4;
    localparam int WIDE = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam int CWW  = (COUNT_BITS > 8) ? COUNT_BITS : 8;

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_LEN,
        PH_PAY,
        PH_FAIL
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic [2:0]        err_reg, err_next;
    logic              out_valid_reg;
    out_item_t         out_item_reg;

    logic              has_result;
    out_item_t         result;
    logic              is_space;
    logic              is_digit;
    logic [3:0]        digit;
    logic [VW-1:0]     scaled;
    logic              over;
    logic [LW-1:0]     limit;
    logic [WIDE-1:0]   max_wide;
    logic [WIDE-1:0]   mask_wide;
    logic [LW-1:0]     rem_dec;
    logic [COUNT_BITS-1:0] count_inc;
    logic [CWW-1:0]    count_wide;
    logic [7:0]        shown;
    logic [2:0]        reason;
    logic [7:0]        b;

    assign b = item.data_byte;

    // effective limit: smaller of the register and the length field's range
    assign max_wide  = WIDE'(max_length);
    assign mask_wide = WIDE'({LW{1'b1}});
    assign limit     = (max_wide < mask_wide) ? max_wide[LW-1:0] : {LW{1'b1}};

    assign is_space = ((b >= 8'd9) && (b <= 8'd13)) || (b == 8'd32);
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign digit    = b[3:0];

    // length * 10 + digit as two shifts and adds
    assign scaled = (VW'(len_reg) << 3) + (VW'(len_reg) << 1) + VW'(digit);
    assign over   = scaled > VW'(limit);

    assign rem_dec   = len_reg - LW'(1);
    assign count_inc = (count_reg == {COUNT_BITS{1'b1}}) ? count_reg
                                                          : count_reg + COUNT_BITS'(1);
    assign count_wide = CWW'(count_reg);
    assign shown      = (count_wide > CWW'(8'hFF)) ? 8'hFF : count_wide[7:0];

    always_comb
    begin
        priority if (phase_reg == PH_FAIL)
            reason = err_reg;
        else if (phase_reg == PH_PAY)
            reason = REASON_TRUNCATED;
        else if (phase_reg == PH_LEN)
            reason = REASON_BAD_TEXT;
        else if (count_reg < COUNT_BITS'(2))
            reason = REASON_FEW;
        else
            reason = REASON_NONE;
    end

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        count_next = count_reg;
        err_next   = err_reg;
        has_result = 1'b0;
        result     = '0;

        if (item.func == FUNC_EOL)
        begin
            // end of line: report and clear the line state
            has_result           = 1'b1;
            result.kind          = (reason != REASON_NONE) ? KIND_REJECT : KIND_ACCEPT;
            result.field_index   = shown;
            result.reject_reason = reason;
            phase_next = PH_SKIP;
            len_next   = '0;
            count_next = '0;
            err_next   = REASON_NONE;
        end
        else
        begin
            unique case (phase_reg)
                PH_SKIP:
                begin
                    if (!is_space)
                    begin
                        if (!is_digit)
                        begin
                            phase_next = PH_FAIL;
                            err_next   = REASON_BAD_TEXT;
                            len_next   = '0;
                        end
                        else if (over)
                        begin
                            phase_next = PH_FAIL;
                            err_next   = REASON_TOO_LARGE;
                            len_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_LEN;
                            len_next   = scaled[LW-1:0];
                        end
                    end
                end
                PH_LEN:
                begin
                    if (is_digit)
                    begin
                        if (over)
                        begin
                            phase_next = PH_FAIL;
                            err_next   = REASON_TOO_LARGE;
                            len_next   = '0;
                        end
                        else
                        begin
                            len_next = scaled[LW-1:0];
                        end
                    end
                    else if (b != COLON_CHAR)
                    begin
                        phase_next = PH_FAIL;
                        err_next   = REASON_BAD_TEXT;
                        len_next   = '0;
                    end
                    else if (len_reg == '0)
                    begin
                        has_result           = 1'b1;
                        result.kind          = KIND_EMPTY;
                        result.field_index   = shown;
                        result.last_of_field = 1'b1;
                        count_next = count_inc;
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        phase_next = PH_PAY;
                    end
                end
                PH_PAY:
                begin
                    has_result           = 1'b1;
                    result.kind          = KIND_PAYLOAD;
                    result.out_byte      = b;
                    result.field_index   = shown;
                    result.last_of_field = (rem_dec == '0);
                    len_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        count_next = count_inc;
                        phase_next = PH_SKIP;
                    end
                end
                PH_FAIL:
                begin
                    // drop bytes until end of line
                end
                default:
                begin
                    phase_next = PH_SKIP;
                end
            endcase
        end
    end

    // a byte with no result never waits on the output side
    assign taken = item_valid && (!has_result || !out_valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_SKIP;
            len_reg       <= '0;
            count_reg     <= '0;
            err_reg       <= REASON_NONE;
            out_valid_reg <= 1'b0;
            out_item_reg  <= '0;
        end
        else
        begin
            if (taken)
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                count_reg <= count_next;
                err_reg   <= err_next;
            end
            if (taken && has_result)
            begin
                out_valid_reg <= 1'b1;
                out_item_reg  <= result;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

@@ hw/rtl/lpfp_checker.sv @@
// ============================================================================
// lpfp_checker: port-level checks of the parser
// Watches both channels and the shape of each output transaction.
// ============================================================================
module lpfp_checker
    import lpfp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_item
);

    // hold a stalled output transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output transaction changed");

    // a reason is given exactly on reject
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_item.kind == KIND_REJECT) ==
                       (out_item.reject_reason != REASON_NONE)))
    else $error("reject reason does not match kind");

    // verdicts carry no byte and no last mark
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.kind == KIND_ACCEPT || out_item.kind == KIND_REJECT)
        |-> (out_item.out_byte == 8'h00) && !out_item.last_of_field)
    else $error("line verdict carries payload fields");

    // a result appears on an empty output only after its input transaction passed the input register and the parse step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("output transaction without input");

endmodule

bind length_prefixed_field_parser lpfp_checker u_checker (.*);
